// File: sv/tld_pkg.sv
// Package: shared types and constants of the terminal line discipline unit
package tld_pkg;

    localparam int LINE_DEPTH   = 256;
    localparam int COOKED_DEPTH = 512;
    localparam int LINE_AW      = $clog2(LINE_DEPTH);
    localparam int COOKED_AW    = $clog2(COOKED_DEPTH);
    localparam int COOKED_CW    = $clog2(COOKED_DEPTH + 1);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] REG_INPUT_MODE = 3'd0;
    localparam logic [2:0] REG_LOCAL_MODE = 3'd1;
    localparam logic [2:0] REG_INTR_CHAR  = 3'd2;
    localparam logic [2:0] REG_ERASE_CHAR = 3'd3;
    localparam logic [2:0] REG_KILL_CHAR  = 3'd4;
    localparam logic [2:0] REG_EOF_CHAR   = 3'd5;

    localparam logic [1:0] KIND_ECHO   = 2'd0;
    localparam logic [1:0] KIND_ERASE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_FLIP  = 8'h40;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_QUEUE_BYTE,
        OP_INTR,
        OP_ERASE,
        OP_KILL,
        OP_EOF,
        OP_NEWLINE,
        OP_STORE
    } op_t;

    // Classified command from the front end to the back end
    typedef struct packed {
        logic       read;
        op_t        op;
        logic [7:0] ch;
        logic       do_echo;
        logic       caret;
    } cmd_t;

    typedef struct packed {
        logic [1:0] record_kind;
        logic [7:0] byte_value;
        logic [7:0] erase_count;
        logic       read_valid;
        logic       eof_seen;
        logic       readable;
        logic       last;
    } rec_t;

    typedef struct packed {
        logic       action;
        logic [7:0] char_in;
        logic       echo_enable;
    } in_t;

endpackage

// File: sv/tld_if.sv
// Interfaces: valid/ready channels for input items and result records
interface tld_in_if;
    logic          valid;
    logic          ready;
    tld_pkg::in_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tld_out_if;
    logic          valid;
    logic          ready;
    tld_pkg::rec_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/tld_front.sv
// Front end: CR/NL translation and classification of input items
module tld_front (
    input  logic                clk,
    input  logic                rst_n,
    tld_in_if.sink              in_ch,
    input  logic [2:0]          input_mode,
    input  logic [3:0]          local_mode,
    input  logic [7:0]          interrupt_char,
    input  logic [7:0]          erase_char,
    input  logic [7:0]          kill_char,
    input  logic [7:0]          eof_char,
    output logic                cmd_valid,
    output tld_pkg::cmd_t       cmd,
    input  logic                cmd_ready
);
    tld_pkg::cmd_t cmd_reg, cmd_next;
    logic          vld_reg;
    logic [7:0]    c;

    assign in_ch.ready = !vld_reg || cmd_ready;
    assign cmd_valid   = vld_reg;
    assign cmd         = cmd_reg;

    always_comb
    begin
        c = in_ch.payload.char_in;
        cmd_next = '0;
        cmd_next.read    = in_ch.payload.action;
        cmd_next.do_echo = in_ch.payload.echo_enable && local_mode[0];
        cmd_next.caret   = local_mode[1];
        cmd_next.op      = tld_pkg::OP_NONE;
        if (c == tld_pkg::CH_CR && input_mode[1])
            c = tld_pkg::CH_NL;
        else if (c == tld_pkg::CH_NL && input_mode[2])
            c = tld_pkg::CH_CR;
        cmd_next.ch = c;
        if (in_ch.payload.action)
            cmd_next.op = tld_pkg::OP_NONE;
        else if (in_ch.payload.char_in == tld_pkg::CH_CR && input_mode[0])
            cmd_next.op = tld_pkg::OP_NONE;
        else if (local_mode[2] && c == interrupt_char)
            cmd_next.op = tld_pkg::OP_INTR;
        else if (!local_mode[3])
            cmd_next.op = tld_pkg::OP_QUEUE_BYTE;
        else if (c == erase_char || c == tld_pkg::CH_BS)
            cmd_next.op = tld_pkg::OP_ERASE;
        else if (c == kill_char)
            cmd_next.op = tld_pkg::OP_KILL;
        else if (c == eof_char)
            cmd_next.op = tld_pkg::OP_EOF;
        else if (c == tld_pkg::CH_NL)
            cmd_next.op = tld_pkg::OP_NEWLINE;
        else if (c != 8'h00 && !c[7])
            cmd_next.op = tld_pkg::OP_STORE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ch.ready)
            vld_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
            cmd_reg <= cmd_next;
    end
endmodule

// File: sv/tld_cmd_fifo.sv
// Command queue between front end and back end
module tld_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  tld_pkg::cmd_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output tld_pkg::cmd_t rd_data
);
    tld_pkg::cmd_t                mem [tld_pkg::QUEUE_DEPTH];
    logic [tld_pkg::QUEUE_AW-1:0] wp_reg, rp_reg;
    logic [tld_pkg::QUEUE_AW:0]   cnt_reg;
    logic                         do_wr, do_rd;

    assign wr_ready = cnt_reg != tld_pkg::QUEUE_AW'(0) + (tld_pkg::QUEUE_AW+1)'(tld_pkg::QUEUE_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (tld_pkg::QUEUE_AW+1)'(do_wr)
                               - (tld_pkg::QUEUE_AW+1)'(do_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wp_reg] <= wr_data;
    end
endmodule

// File: sv/tld_back.sv
// Back end: line editing, cooked queue, line flush and record output
module tld_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  tld_pkg::cmd_t cmd,
    tld_out_if.source     out_ch
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_FLUSH_RD,
        S_FLUSH_WR,
        S_DEQ,
        S_EMIT
    } state_t;

    state_t state_reg;
    tld_pkg::cmd_t cur_reg;

    logic [7:0] line_mem   [tld_pkg::LINE_DEPTH];
    logic [7:0] cooked_mem [tld_pkg::COOKED_DEPTH];

    logic [tld_pkg::LINE_AW:0]     line_len_reg;
    logic [tld_pkg::LINE_AW:0]     idx_reg;
    logic [tld_pkg::COOKED_AW-1:0] head_reg, tail_reg;
    logic [tld_pkg::COOKED_CW-1:0] count_reg;
    logic                          eof_reg;
    logic                          add_nl_reg;
    logic [7:0]                    line_rd_reg, cooked_rd_reg;

    tld_pkg::rec_t rec_reg [3];
    logic [2:0]    nrec_reg, ridx_reg;

    logic          full;
    logic          out_vld_reg;
    tld_pkg::rec_t out_reg;

    logic                          cq_we;
    logic [7:0]                    cq_wd;
    logic                          lw_we;

    assign full      = count_reg == tld_pkg::COOKED_CW'(tld_pkg::COOKED_DEPTH);
    assign cmd_ready = state_reg == S_IDLE;
    assign out_ch.valid   = out_vld_reg;
    assign out_ch.payload = out_reg;

    function automatic tld_pkg::rec_t mk_echo(input logic [7:0] b);
        tld_pkg::rec_t r;
        r = '0;
        r.record_kind = tld_pkg::KIND_ECHO;
        r.byte_value  = b;
        return r;
    endfunction

    function automatic tld_pkg::rec_t mk_erase(input logic [7:0] n);
        tld_pkg::rec_t r;
        r = '0;
        r.record_kind = tld_pkg::KIND_ERASE;
        r.erase_count = n;
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cq_we)
            cooked_mem[tail_reg] <= cq_wd;
        if (lw_we)
            line_mem[line_len_reg[tld_pkg::LINE_AW-1:0]] <= cur_reg.ch;
        line_rd_reg   <= line_mem[idx_reg[tld_pkg::LINE_AW-1:0]];
        cooked_rd_reg <= cooked_mem[head_reg];
    end

    always_comb
    begin
        cq_we = 1'b0;
        cq_wd = cur_reg.ch;
        lw_we = 1'b0;
        if (state_reg == S_IDLE && cmd_valid && !full)
        begin
            cq_wd = cmd.ch;
            cq_we = !cmd.read && (cmd.op == tld_pkg::OP_QUEUE_BYTE);
            if (!cmd.read && cmd.op == tld_pkg::OP_INTR)
            begin
                cq_we = 1'b1;
                cq_wd = tld_pkg::CH_NL;
            end
        end
        else if (state_reg == S_FLUSH_WR && !full)
        begin
            if (idx_reg < line_len_reg)
            begin
                cq_we = 1'b1;
                cq_wd = line_rd_reg;
            end
            else if (add_nl_reg)
            begin
                cq_we = 1'b1;
                cq_wd = tld_pkg::CH_NL;
            end
        end
        else if (state_reg == S_EMIT && ridx_reg == 3'd0)
            lw_we = cur_reg.op == tld_pkg::OP_STORE && !cur_reg.read
                    && (line_len_reg + 1'b1 < (tld_pkg::LINE_AW+1)'(tld_pkg::LINE_DEPTH));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            line_len_reg <= '0;
            idx_reg      <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            eof_reg      <= 1'b0;
            add_nl_reg   <= 1'b0;
            nrec_reg     <= '0;
            ridx_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (out_vld_reg && out_ch.ready
                && !(state_reg == S_EMIT && ridx_reg != 3'd0))
                out_vld_reg <= 1'b0;
            if (cq_we)
            begin
                tail_reg  <= tail_reg + 1'b1;
                count_reg <= count_reg + 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        logic [7:0]    e1;
                        state_t        st;
                        logic [2:0]    nr;
                        tld_pkg::rec_t r0, r1, r2;
                        e1 = (cmd.ch == tld_pkg::CH_DEL) ? tld_pkg::CH_QUEST
                                                         : (cmd.ch ^ tld_pkg::CH_FLIP);
                        st = S_EMIT;
                        nr = '0;
                        r0 = '0;
                        r1 = '0;
                        r2 = '0;
                        cur_reg  <= cmd;
                        ridx_reg <= '0;
                        if (cmd.read)
                        begin
                            if (count_reg != '0)
                                st = S_DEQ;
                        end
                        else
                        begin
                            case (cmd.op)
                                tld_pkg::OP_INTR:
                                begin
                                    line_len_reg <= '0;
                                    if (cmd.do_echo)
                                    begin
                                        if (!cmd.ch[7])
                                        begin
                                            r0 = mk_echo(tld_pkg::CH_CARET);
                                            r1 = mk_echo(e1);
                                            r2 = mk_echo(tld_pkg::CH_NL);
                                            nr = 3'd3;
                                        end
                                        else
                                        begin
                                            r0 = mk_echo(tld_pkg::CH_NL);
                                            nr = 3'd1;
                                        end
                                    end
                                end
                                tld_pkg::OP_QUEUE_BYTE, tld_pkg::OP_NEWLINE,
                                tld_pkg::OP_STORE:
                                begin
                                    if (cmd.do_echo && !(cmd.op == tld_pkg::OP_STORE
                                        && line_len_reg + 1'b1 >=
                                           (tld_pkg::LINE_AW+1)'(tld_pkg::LINE_DEPTH)))
                                    begin
                                        if (cmd.ch == tld_pkg::CH_NL
                                            || (cmd.ch >= 8'd32 && cmd.ch <= 8'd126))
                                        begin
                                            r0 = mk_echo(cmd.ch);
                                            nr = 3'd1;
                                        end
                                        else if (cmd.caret && !cmd.ch[7])
                                        begin
                                            r0 = mk_echo(tld_pkg::CH_CARET);
                                            r1 = mk_echo(e1);
                                            nr = 3'd2;
                                        end
                                    end
                                    if (cmd.op == tld_pkg::OP_NEWLINE)
                                    begin
                                        add_nl_reg <= 1'b1;
                                        idx_reg    <= '0;
                                        st = S_FLUSH_RD;
                                    end
                                end
                                tld_pkg::OP_ERASE:
                                begin
                                    if (line_len_reg != '0)
                                    begin
                                        line_len_reg <= line_len_reg - 1'b1;
                                        if (cmd.do_echo)
                                        begin
                                            r0 = mk_erase(8'd1);
                                            nr = 3'd1;
                                        end
                                    end
                                end
                                tld_pkg::OP_KILL:
                                begin
                                    if (line_len_reg != '0 && cmd.do_echo)
                                    begin
                                        r0 = mk_erase(
                                            (line_len_reg > (tld_pkg::LINE_AW+1)'(255))
                                            ? 8'd255 : 8'(line_len_reg));
                                        nr = 3'd1;
                                    end
                                    line_len_reg <= '0;
                                end
                                tld_pkg::OP_EOF:
                                begin
                                    if (line_len_reg == '0)
                                        eof_reg <= 1'b1;
                                    else
                                    begin
                                        add_nl_reg <= 1'b0;
                                        idx_reg    <= '0;
                                        st = S_FLUSH_RD;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        state_reg  <= st;
                        nrec_reg   <= nr;
                        rec_reg[0] <= r0;
                        rec_reg[1] <= r1;
                        rec_reg[2] <= r2;
                    end
                end
                S_FLUSH_RD:
                    state_reg <= S_FLUSH_WR;
                S_FLUSH_WR:
                begin
                    if (full || idx_reg >= line_len_reg)
                    begin
                        line_len_reg <= '0;
                        state_reg    <= S_EMIT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_FLUSH_RD;
                    end
                end
                S_DEQ:
                begin
                    rec_reg[0].byte_value <= cooked_rd_reg;
                    rec_reg[0].read_valid <= 1'b1;
                    head_reg  <= head_reg + 1'b1;
                    count_reg <= count_reg - 1'b1;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (ridx_reg == 3'd0 && cur_reg.op == tld_pkg::OP_STORE
                        && !cur_reg.read && lw_we)
                        line_len_reg <= line_len_reg + 1'b1;
                    if (ridx_reg == 3'd0)
                        ridx_reg <= 3'd1;
                    else if (!out_vld_reg || out_ch.ready)
                    begin
                        out_vld_reg <= 1'b1;
                        if (ridx_reg - 3'd1 < nrec_reg)
                        begin
                            out_reg  <= rec_reg[2'(ridx_reg - 3'd1)];
                            ridx_reg <= ridx_reg + 1'b1;
                        end
                        else
                        begin
                            tld_pkg::rec_t s;
                            s = '0;
                            s.record_kind = tld_pkg::KIND_STATUS;
                            s.last        = 1'b1;
                            s.readable    = (count_reg != '0) || eof_reg;
                            if (cur_reg.read)
                            begin
                                if (nrec_reg == '0 && rec_reg[0].read_valid)
                                begin
                                    s.byte_value = rec_reg[0].byte_value;
                                    s.read_valid = 1'b1;
                                end
                                else if (eof_reg)
                                begin
                                    s.eof_seen = 1'b1;
                                    s.readable = 1'b0;
                                    eof_reg    <= 1'b0;
                                end
                            end
                            out_reg   <= s;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: sv/terminal_line_discipline_unit.sv
// Top level: terminal input line discipline with canonical line editing
//  channel  dir  payload                                  handshake
//  in_ch    in   action, char_in, echo_enable             valid/ready
//  out_ch   out  record_kind..last (1 to 4 per item)      valid/ready
//  cfg      in   cfg_we, cfg_index, cfg_data              write enable
// The back end takes one item at a time: S_IDLE, S_DEQ for a read that
// dequeues, then S_EMIT for echo records and status. A newline or EOF flush
// runs S_FLUSH_RD then S_FLUSH_WR per line byte (registered line memory read
// then queue write). The front register and command queue precede it.
// Reset clears all control state; line and cooked memories are not cleared.
// The front end and a 4-entry command queue keep accepting, until the queue
// is full, while the back end stalls on out_ch.ready.
module terminal_line_discipline_unit (
    input  logic       clk,
    input  logic       rst_n,
    tld_in_if.sink     in_ch,
    tld_out_if.source  out_ch,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);
    logic [2:0] input_mode_reg;
    logic [3:0] local_mode_reg;
    logic [7:0] intr_reg, erase_reg, kill_reg, eof_reg;

    logic          f_valid, f_ready, q_valid, q_ready;
    tld_pkg::cmd_t f_cmd, q_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_mode_reg <= 3'd2;
            local_mode_reg <= 4'd15;
            intr_reg       <= 8'h03;
            erase_reg      <= 8'h7F;
            kill_reg       <= 8'h15;
            eof_reg        <= 8'h04;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tld_pkg::REG_INPUT_MODE: input_mode_reg <= cfg_data[2:0];
                tld_pkg::REG_LOCAL_MODE: local_mode_reg <= cfg_data[3:0];
                tld_pkg::REG_INTR_CHAR:  intr_reg       <= cfg_data;
                tld_pkg::REG_ERASE_CHAR: erase_reg      <= cfg_data;
                tld_pkg::REG_KILL_CHAR:  kill_reg       <= cfg_data;
                tld_pkg::REG_EOF_CHAR:   eof_reg        <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    tld_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .input_mode(input_mode_reg), .local_mode(local_mode_reg),
        .interrupt_char(intr_reg), .erase_char(erase_reg),
        .kill_char(kill_reg), .eof_char(eof_reg),
        .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
    );

    tld_cmd_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
    );

    tld_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .out_ch(out_ch)
    );
endmodule

// File: sv/tld_checker.sv
// Checker: port-level properties of the terminal line discipline unit
module tld_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          out_valid,
    input logic          out_ready,
    input tld_pkg::rec_t out_payload
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("output record changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_payload.last == (out_payload.record_kind == tld_pkg::KIND_STATUS)))
        else $error("last flag does not match status kind");

    a_rv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_payload.read_valid || out_payload.eof_seen)
        |-> out_payload.record_kind == tld_pkg::KIND_STATUS
            && !(out_payload.read_valid && out_payload.eof_seen))
        else $error("bad status flags");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_payload.record_kind <= tld_pkg::KIND_STATUS)
        else $error("bad record kind");
endmodule

bind terminal_line_discipline_unit tld_checker u_tld_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .out_payload(out_ch.payload)
);
